>>> hw/rtl/color_blob_centroid_core_defines.svh
// assertion macros for the color blob centroid core
`ifndef COLOR_BLOB_CENTROID_CORE_DEFINES_SVH
`define COLOR_BLOB_CENTROID_CORE_DEFINES_SVH

// same-cycle implication
`define CBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cbc_pkg.sv
// shared types and constants for the color blob centroid core
`default_nettype none
package cbc_pkg;

    localparam int FRAME_DIM   = 2048;
    localparam int COORD_W     = 11;
    localparam int CHAN_W      = 8;
    localparam int BGR_W       = 24;
    localparam int CROP_LEN_W  = 12;
    localparam int SUM_W       = 34;
    localparam int COUNT_W     = 23;
    localparam int CENTER_W    = 12;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS   = CENTER_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int DIVISOR_W   = COUNT_W + CENTER_W;

    localparam logic [BGR_W-1:0]      LOWER_BGR_RST   = 24'd12171641;
    localparam logic [BGR_W-1:0]      UPPER_BGR_RST   = 24'd13164967;
    localparam logic [COORD_W-1:0]    CROP_LEFT_RST   = 11'd150;
    localparam logic [COORD_W-1:0]    CROP_TOP_RST    = 11'd50;
    localparam logic [CROP_LEN_W-1:0] CROP_WIDTH_RST  = 12'd275;
    localparam logic [CROP_LEN_W-1:0] CROP_HEIGHT_RST = 12'd430;
    localparam logic [COUNT_W-1:0]    MIN_POINTS_RST  = 23'd20;

    localparam logic [CENTER_W-1:0]   MEAN_MAX        = 12'd2047;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LOWER_BGR   = 3'd0,
        CFG_UPPER_BGR   = 3'd1,
        CFG_CROP_LEFT   = 3'd2,
        CFG_CROP_TOP    = 3'd3,
        CFG_CROP_WIDTH  = 3'd4,
        CFG_CROP_HEIGHT = 3'd5,
        CFG_MIN_POINTS  = 3'd6
    } t_cfg_addr;

    typedef struct packed {
        logic [BGR_W-1:0]      lower_bgr;
        logic [BGR_W-1:0]      upper_bgr;
        logic [COORD_W-1:0]    crop_left;
        logic [COORD_W-1:0]    crop_top;
        logic [CROP_LEN_W-1:0] crop_width;
        logic [CROP_LEN_W-1:0] crop_height;
        logic [COUNT_W-1:0]    min_points;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [COUNT_W-1:0] count;
    } t_frame_sums;

endpackage
`default_nettype wire

>>> hw/rtl/cbc_pix_if.sv
// pixel item channel
`default_nettype none
interface cbc_pix_if
    import cbc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic               frame_end;

    modport source (output valid, pixel_x, pixel_y, blue, green, red, frame_end, input ready);
    modport sink   (input valid, pixel_x, pixel_y, blue, green, red, frame_end, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cbc_res_if.sv
// centroid result channel
`default_nettype none
interface cbc_res_if
    import cbc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic                       found;

    modport source (output valid, center_x, center_y, found, input ready);
    modport sink   (input valid, center_x, center_y, found, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cbc_cfg_if.sv
// configuration write channel
`default_nettype none
interface cbc_cfg_if
    import cbc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cbc_front.sv
// front end: crop, color threshold and running sums per frame
`default_nettype none
module cbc_front
    import cbc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cbc_pix_if.sink          i_pix,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_frame_sums      o_push_data
);

    logic [SUM_W-1:0]   r_sum_x, n_sum_x;
    logic [SUM_W-1:0]   r_sum_y, n_sum_y;
    logic [COUNT_W-1:0] r_count, n_count;

    logic               accept;
    logic               in_x, in_y, hit;
    logic [COORD_W-1:0] off_x, off_y;
    logic [CHAN_W-1:0]  b, g, r;
    logic [SUM_W:0]     add_x, add_y;

    assign i_pix.ready = !i_q_full;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        off_x = i_pix.pixel_x - i_cfg.crop_left;
        off_y = i_pix.pixel_y - i_cfg.crop_top;
        in_x  = (i_pix.pixel_x >= i_cfg.crop_left)
              && ({1'b0, off_x} < i_cfg.crop_width)
              && (32'(i_pix.pixel_x) < FRAME_DIM);
        in_y  = (i_pix.pixel_y >= i_cfg.crop_top)
              && ({1'b0, off_y} < i_cfg.crop_height)
              && (32'(i_pix.pixel_y) < FRAME_DIM);
        b = (in_x && in_y) ? i_pix.blue  : '0;
        g = (in_x && in_y) ? i_pix.green : '0;
        r = (in_x && in_y) ? i_pix.red   : '0;
        hit = (b >= i_cfg.lower_bgr[7:0])   && (b <= i_cfg.upper_bgr[7:0])
            && (g >= i_cfg.lower_bgr[15:8])  && (g <= i_cfg.upper_bgr[15:8])
            && (r >= i_cfg.lower_bgr[23:16]) && (r <= i_cfg.upper_bgr[23:16]);

        add_x = {1'b0, r_sum_x} + (SUM_W + 1)'(i_pix.pixel_x);
        add_y = {1'b0, r_sum_y} + (SUM_W + 1)'(i_pix.pixel_y);

        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;
        n_count = r_count;
        if (hit) begin
            n_sum_x = add_x[SUM_W] ? '1 : add_x[SUM_W-1:0];
            n_sum_y = add_y[SUM_W] ? '1 : add_y[SUM_W-1:0];
            n_count = (r_count == '1) ? r_count : r_count + 1'b1;
        end

        o_push            = accept && i_pix.frame_end;
        o_push_data.sum_x = n_sum_x;
        o_push_data.sum_y = n_sum_y;
        o_push_data.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (i_pix.frame_end) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_count <= '0;
            end else begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_count <= n_count;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/cbc_queue.sv
// short queue of finished frame sums between front and back
`default_nettype none
module cbc_queue
    import cbc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_frame_sums i_push_data,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_empty,
    output t_frame_sums      o_head
);

    t_frame_sums        r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_fill;

    assign o_full  = (r_fill == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/cbc_back.sv
// back end: bit-serial mean division and result register
`default_nettype none
`include "color_blob_centroid_core_defines.svh"
module cbc_back
    import cbc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_q_empty,
    input  wire t_frame_sums i_q_head,
    output logic             o_pop,
    cbc_res_if.source        o_res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_back_state;

    t_back_state             r_state, n_state;
    logic [SUM_W-1:0]        r_rem_x, r_rem_y;
    logic [DIVISOR_W-1:0]    r_dv;
    logic [CENTER_W-1:0]     r_qx, r_qy;
    logic [STEP_W-1:0]       r_step;
    logic                    r_found;

    logic                    r_out_valid;
    logic [CENTER_W-1:0]     r_out_x, r_out_y;
    logic                    r_out_found;

    logic                    ge_x, ge_y;
    logic [DIVISOR_W-1:0]    dif_x, dif_y;
    logic                    out_free, out_load;
    logic [CENTER_W-1:0]     mean_x, mean_y;

    assign o_res.valid    = r_out_valid;
    assign o_res.center_x = r_out_x;
    assign o_res.center_y = r_out_y;
    assign o_res.found    = r_out_found;

    assign out_free = !r_out_valid || o_res.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign out_load = (r_state == S_DONE) && out_free;

    always_comb begin
        dif_x = DIVISOR_W'(r_rem_x) - r_dv;
        dif_y = DIVISOR_W'(r_rem_y) - r_dv;
        ge_x  = DIVISOR_W'(r_rem_x) >= r_dv;
        ge_y  = DIVISOR_W'(r_rem_y) >= r_dv;
        mean_x = r_qx[CENTER_W-1] ? MEAN_MAX : {1'b0, r_qx[CENTER_W-2:0]};
        mean_y = r_qy[CENTER_W-1] ? MEAN_MAX : {1'b0, r_qy[CENTER_W-2:0]};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_head.count > i_cfg.min_points) ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem_x <= i_q_head.sum_x;
            r_rem_y <= i_q_head.sum_y;
            r_dv    <= DIVISOR_W'({i_q_head.count, (CENTER_W - 1)'(0)});
            r_qx    <= '0;
            r_qy    <= '0;
            r_step  <= STEP_W'(DIV_STEPS - 1);
            r_found <= i_q_head.count > i_cfg.min_points;
        end else if (r_state == S_DIV) begin
            if (ge_x) begin
                r_rem_x <= dif_x[SUM_W-1:0];
            end
            if (ge_y) begin
                r_rem_y <= dif_y[SUM_W-1:0];
            end
            r_qx   <= {r_qx[CENTER_W-2:0], ge_x};
            r_qy   <= {r_qy[CENTER_W-2:0], ge_y};
            r_dv   <= r_dv >> 1;
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x     <= r_found ? mean_x : '1;
            r_out_y     <= r_found ? mean_y : '1;
            r_out_found <= r_found;
        end
    end

    `CBC_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_dv != '0,
        "divisor is zero during division")
    `CBC_ASSERT_IMP(a_miss_all_ones, i_clk, i_rst_n, r_out_valid && !r_out_found,
        (r_out_x == '1) && (r_out_y == '1), "missing centroid is not all ones")
    `CBC_ASSERT_NEXT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop, r_state != S_IDLE,
        "pop did not start work")
    `CBC_ASSERT_IMP(a_found_in_range, i_clk, i_rst_n, r_out_valid && r_out_found,
        !r_out_x[CENTER_W-1] && !r_out_y[CENTER_W-1], "found centroid out of range")

endmodule
`default_nettype wire

>>> hw/rtl/color_blob_centroid_core.sv
// top level: configuration registers, front end, frame queue and back end
// latency: a pixel enters the running sums in the cycle it is accepted
// frame result: queue, mean divider, result register; too few matches skip the divider
// throughput: one pixel per cycle; the 12-step mean divider takes one frame at a time
// the pixel side stalls only when two finished frames wait in the queue
// reset: synchronous active low, restores register defaults and clears sums and queue
`default_nettype none
module color_blob_centroid_core
    import cbc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cbc_cfg_if.sink    i_cfg,
    cbc_pix_if.sink    i_pix,
    cbc_res_if.source  o_res
);

    t_cfg        r_cfg;
    logic        q_full, q_empty, q_push, q_pop;
    t_frame_sums q_push_data, q_head;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_bgr   <= LOWER_BGR_RST;
            r_cfg.upper_bgr   <= UPPER_BGR_RST;
            r_cfg.crop_left   <= CROP_LEFT_RST;
            r_cfg.crop_top    <= CROP_TOP_RST;
            r_cfg.crop_width  <= CROP_WIDTH_RST;
            r_cfg.crop_height <= CROP_HEIGHT_RST;
            r_cfg.min_points  <= MIN_POINTS_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_addr'(i_cfg.addr))
                CFG_LOWER_BGR:   r_cfg.lower_bgr   <= i_cfg.data[BGR_W-1:0];
                CFG_UPPER_BGR:   r_cfg.upper_bgr   <= i_cfg.data[BGR_W-1:0];
                CFG_CROP_LEFT:   r_cfg.crop_left   <= i_cfg.data[COORD_W-1:0];
                CFG_CROP_TOP:    r_cfg.crop_top    <= i_cfg.data[COORD_W-1:0];
                CFG_CROP_WIDTH:  r_cfg.crop_width  <= i_cfg.data[CROP_LEN_W-1:0];
                CFG_CROP_HEIGHT: r_cfg.crop_height <= i_cfg.data[CROP_LEN_W-1:0];
                CFG_MIN_POINTS:  r_cfg.min_points  <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    cbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    cbc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    cbc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// self-checking testbench for the color blob centroid core: directed rows, then random frames
`default_nettype none
module tb_top
    import cbc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES   = 250000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_GAP        = 14;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 125;
    localparam int PRESSURE_PHASE = 4;
    localparam int BIG_MIN_PHASE  = 6;
    localparam int MAX_REPORTS    = 10;

    localparam longint unsigned SUM_LIMIT   = (64'd1 << SUM_W) - 1;
    localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_W) - 1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic               frame_end;
    } pixel_item_t;

    typedef struct packed {
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic                       found;
    } centroid_t;

    typedef struct {
        bit        typed;
        centroid_t want;
    } frame_note_t;

    typedef enum bit {ROW_PIXEL, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        t_cfg_addr             addr;
        logic [CFG_DATA_W-1:0] data;
        pixel_item_t           pix;
        bit                    typed;
        centroid_t             want;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    cbc_cfg_if cfg_bus ();
    cbc_pix_if pix_bus ();
    cbc_res_if res_bus ();

    color_blob_centroid_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_res   (res_bus)
    );

    t_cfg            model_cfg;
    longint unsigned column_total;
    longint unsigned row_total;
    longint unsigned match_total;
    centroid_t       pending_centroids[$];
    frame_note_t     frame_notes[$];
    stim_row_t       directed_rows[$];
    int              mismatches;
    bit              no_idle;
    bit              hold_request;
    int              cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic bit span_hit(logic [COORD_W-1:0] pos, logic [COORD_W-1:0] start,
                                    logic [CROP_LEN_W-1:0] len);
        return pos >= start && (int'(pos) - int'(start)) < int'(len) && int'(pos) < FRAME_DIM;
    endfunction

    // adds one matching pixel to the frame sums, returns 1 with the centroid on the last pixel
    function automatic bit accumulate_pixel(input pixel_item_t p, output centroid_t c);
        logic [CHAN_W-1:0] b, g, r;
        logic [BGR_W-1:0]  lo, hi;
        longint unsigned   mx, my;
        c = '0;
        lo = model_cfg.lower_bgr;
        hi = model_cfg.upper_bgr;
        if (span_hit(p.x, model_cfg.crop_left, model_cfg.crop_width) &&
            span_hit(p.y, model_cfg.crop_top, model_cfg.crop_height)) begin
            b = p.blue;
            g = p.green;
            r = p.red;
        end else begin
            b = '0;
            g = '0;
            r = '0;
        end
        if (b >= lo[7:0] && b <= hi[7:0] && g >= lo[15:8] && g <= hi[15:8] &&
            r >= lo[23:16] && r <= hi[23:16]) begin
            column_total = (column_total + p.x > SUM_LIMIT) ? SUM_LIMIT : column_total + p.x;
            row_total    = (row_total + p.y > SUM_LIMIT) ? SUM_LIMIT : row_total + p.y;
            match_total  = (match_total + 1 > COUNT_LIMIT) ? COUNT_LIMIT : match_total + 1;
        end
        if (!p.frame_end) begin
            return 1'b0;
        end
        if (match_total > model_cfg.min_points) begin
            mx = column_total / match_total;
            my = row_total / match_total;
            if (mx > MEAN_MAX) mx = MEAN_MAX;
            if (my > MEAN_MAX) my = MEAN_MAX;
            c.cx = mx[CENTER_W-1:0];
            c.cy = my[CENTER_W-1:0];
            c.found = 1'b1;
        end else begin
            c.cx = '1;
            c.cy = '1;
            c.found = 1'b0;
        end
        column_total = 0;
        row_total = 0;
        match_total = 0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        pixel_item_t p;
        centroid_t   got;
        centroid_t   want;
        centroid_t   made;
        frame_note_t note;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.addr)
                    CFG_LOWER_BGR:   model_cfg.lower_bgr   = cfg_bus.data[BGR_W-1:0];
                    CFG_UPPER_BGR:   model_cfg.upper_bgr   = cfg_bus.data[BGR_W-1:0];
                    CFG_CROP_LEFT:   model_cfg.crop_left   = cfg_bus.data[COORD_W-1:0];
                    CFG_CROP_TOP:    model_cfg.crop_top    = cfg_bus.data[COORD_W-1:0];
                    CFG_CROP_WIDTH:  model_cfg.crop_width  = cfg_bus.data[CROP_LEN_W-1:0];
                    CFG_CROP_HEIGHT: model_cfg.crop_height = cfg_bus.data[CROP_LEN_W-1:0];
                    CFG_MIN_POINTS:  model_cfg.min_points  = cfg_bus.data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (res_bus.valid && res_bus.ready) begin
                got.cx = res_bus.center_x;
                got.cy = res_bus.center_y;
                got.found = res_bus.found;
                if (pending_centroids.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected centroid x=%0d y=%0d found=%0b",
                                 got.cx, got.cy, got.found);
                    mismatches++;
                end else begin
                    want = pending_centroids.pop_front();
                    if (got.cx !== want.cx || got.cy !== want.cy ||
                        got.found !== want.found) begin
                        if (mismatches < MAX_REPORTS)
                            $display("centroid wrong: exp %0d %0d %0b, got %0d %0d %0b",
                                     want.cx, want.cy, want.found,
                                     got.cx, got.cy, got.found);
                        mismatches++;
                    end
                end
            end
            if (pix_bus.valid && pix_bus.ready) begin
                p.x = pix_bus.pixel_x;
                p.y = pix_bus.pixel_y;
                p.blue = pix_bus.blue;
                p.green = pix_bus.green;
                p.red = pix_bus.red;
                p.frame_end = pix_bus.frame_end;
                if (accumulate_pixel(p, made)) begin
                    note.typed = 1'b0;
                    if (frame_notes.size() != 0)
                        note = frame_notes.pop_front();
                    pending_centroids.push_back(note.typed ? note.want : made);
                end
            end
        end
    end

    // result side: random stalls per item unless no_idle is set, one long hold-off on request
    initial begin : result_sink
        int gap;
        res_bus.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_request) begin
                res_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0) begin
                    res_bus.ready = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            res_bus.ready = 1'b1;
            do @(posedge i_clk); while (!(res_bus.valid && res_bus.ready));
            @(negedge i_clk);
        end
    end

    task automatic row_cfg(t_cfg_addr a, int unsigned d);
        stim_row_t row;
        row.kind = ROW_CONFIG;
        row.addr = a;
        row.data = d[CFG_DATA_W-1:0];
        row.pix = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endtask

    task automatic row_pix(int x, int y, int b, int g, int r);
        stim_row_t row;
        row.kind = ROW_PIXEL;
        row.addr = CFG_LOWER_BGR;
        row.data = '0;
        row.pix = '{x: COORD_W'(x), y: COORD_W'(y), blue: CHAN_W'(b), green: CHAN_W'(g),
                    red: CHAN_W'(r), frame_end: 1'b0};
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endtask

    task automatic row_end(int x, int y, int b, int g, int r, int cx, int cy, bit found);
        stim_row_t row;
        row.kind = ROW_PIXEL;
        row.addr = CFG_LOWER_BGR;
        row.data = '0;
        row.pix = '{x: COORD_W'(x), y: COORD_W'(y), blue: CHAN_W'(b), green: CHAN_W'(g),
                    red: CHAN_W'(r), frame_end: 1'b1};
        row.typed = 1'b1;
        row.want.cx = CENTER_W'(cx);
        row.want.cy = CENTER_W'(cy);
        row.want.found = found;
        directed_rows.push_back(row);
    endtask

    task automatic write_reg(t_cfg_addr a, logic [CFG_DATA_W-1:0] d);
        cfg_bus.addr = a;
        cfg_bus.data = d;
        cfg_bus.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_pixel(pixel_item_t p, bit typed, centroid_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (p.frame_end)
            frame_notes.push_back('{typed: typed, want: want});
        if (gap > 0) begin
            pix_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_bus.pixel_x = p.x;
        pix_bus.pixel_y = p.y;
        pix_bus.blue = p.blue;
        pix_bus.green = p.green;
        pix_bus.red = p.red;
        pix_bus.frame_end = p.frame_end;
        pix_bus.valid = 1'b1;
        do @(posedge i_clk); while (!pix_bus.ready);
        @(negedge i_clk);
    endtask

    // all frames closed; wait for the last centroid and the divider to settle
    task automatic wait_idle();
        pix_bus.valid = 1'b0;
        while (pending_centroids.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int pick_coord(int start, int len);
        int v;
        if (len > 0 && $urandom_range(0, 3) != 0) begin
            v = start + $urandom_range(0, len - 1);
            if (v < FRAME_DIM) return v;
        end
        return $urandom_range(0, FRAME_DIM - 1);
    endfunction

    function automatic int pick_level(int lo, int hi);
        if (lo <= hi && $urandom_range(0, 3) != 0) return $urandom_range(lo, hi);
        return $urandom_range(0, 255);
    endfunction

    initial begin : stimulus
        pixel_item_t           p;
        logic [CFG_DATA_W-1:0] lo_bgr;
        logic [CFG_DATA_W-1:0] hi_bgr;
        int                    lo_c;
        int                    hi_c;
        int                    swap;
        int                    len;
        int                    sent;
        int                    left;
        int                    top;
        int                    width;
        int                    height;
        int                    min_pts;
        bit                    after_pixels;

        model_cfg = '{lower_bgr: LOWER_BGR_RST, upper_bgr: UPPER_BGR_RST,
                      crop_left: CROP_LEFT_RST, crop_top: CROP_TOP_RST,
                      crop_width: CROP_WIDTH_RST, crop_height: CROP_HEIGHT_RST,
                      min_points: MIN_POINTS_RST};
        column_total = 0;
        row_total = 0;
        match_total = 0;
        mismatches = 0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.addr = '0;
        cfg_bus.data = '0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel_x = '0;
        pix_bus.pixel_y = '0;
        pix_bus.blue = '0;
        pix_bus.green = '0;
        pix_bus.red = '0;
        pix_bus.frame_end = 1'b0;
        i_rst_n = 1'b0;

        // register defaults: corners of the crop, each bound and one off it
        row_pix(150, 50, 121, 185, 185);
        row_pix(424, 479, 167, 225, 200);
        row_pix(149, 50, 150, 200, 190);
        row_pix(425, 479, 150, 200, 190);
        row_pix(150, 49, 150, 200, 190);
        row_pix(150, 480, 150, 200, 190);
        row_pix(300, 300, 120, 200, 190);
        row_pix(300, 300, 168, 200, 190);
        row_pix(300, 300, 150, 184, 190);
        row_pix(300, 300, 150, 226, 190);
        row_pix(300, 300, 150, 200, 184);
        row_pix(300, 300, 150, 200, 201);
        row_end(2047, 2047, 255, 255, 255, -1, -1, 1'b0);
        // empty crop, black passes
        row_cfg(CFG_MIN_POINTS, 0);
        row_cfg(CFG_LOWER_BGR, 0);
        row_cfg(CFG_UPPER_BGR, 24'hFFFFFF);
        row_cfg(CFG_CROP_WIDTH, 0);
        row_pix(0, 0, 255, 255, 255);
        row_end(2047, 2047, 0, 0, 0, 1023, 1023, 1'b1);
        row_end(2047, 0, 17, 34, 51, 2047, 0, 1'b1);
        // zero height, only black matches
        row_cfg(CFG_UPPER_BGR, 0);
        row_cfg(CFG_CROP_LEFT, 0);
        row_cfg(CFG_CROP_WIDTH, 2048);
        row_cfg(CFG_CROP_HEIGHT, 0);
        row_pix(5, 7, 200, 10, 30);
        row_end(9, 3, 255, 255, 255, 7, 5, 1'b1);
        // crop running past the image edge
        row_cfg(CFG_LOWER_BGR, 24'h010101);
        row_cfg(CFG_UPPER_BGR, 24'hFFFFFF);
        row_cfg(CFG_CROP_LEFT, 2047);
        row_cfg(CFG_CROP_TOP, 2047);
        row_cfg(CFG_CROP_WIDTH, 2048);
        row_cfg(CFG_CROP_HEIGHT, 4095);
        row_pix(2046, 2047, 255, 255, 255);
        row_pix(2047, 2046, 255, 255, 255);
        row_end(2047, 2047, 1, 1, 1, 2047, 2047, 1'b1);
        // minimum of 4194304, too few matches
        row_cfg(CFG_MIN_POINTS, 4194304);
        row_cfg(CFG_LOWER_BGR, 0);
        row_pix(0, 0, 0, 0, 0);
        row_end(100, 100, 9, 9, 9, -1, -1, 1'b0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        after_pixels = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                if (after_pixels) wait_idle();
                after_pixels = 1'b0;
                write_reg(directed_rows[i].addr, directed_rows[i].data);
            end else begin
                send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
                after_pixels = 1'b1;
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            if (phase == 0) begin
                lo_bgr = LOWER_BGR_RST;
                hi_bgr = UPPER_BGR_RST;
                left = int'(CROP_LEFT_RST);
                top = int'(CROP_TOP_RST);
                width = int'(CROP_WIDTH_RST);
                height = int'(CROP_HEIGHT_RST);
                min_pts = int'(MIN_POINTS_RST);
            end else begin
                for (int c = 0; c < 3; c++) begin
                    lo_c = $urandom_range(0, 255);
                    hi_c = $urandom_range(lo_c, 255);
                    if ($urandom_range(0, 7) == 0) begin
                        swap = lo_c;
                        lo_c = hi_c;
                        hi_c = swap;
                    end
                    if ($urandom_range(0, 5) == 0) lo_c = 0;
                    lo_bgr[c*CHAN_W +: CHAN_W] = CHAN_W'(lo_c);
                    hi_bgr[c*CHAN_W +: CHAN_W] = CHAN_W'(hi_c);
                end
                if ($urandom_range(0, 4) == 0) begin
                    left = 0;
                    top = 0;
                    width = FRAME_DIM;
                    height = FRAME_DIM;
                end else begin
                    left = $urandom_range(0, FRAME_DIM - 1);
                    top = $urandom_range(0, FRAME_DIM - 1);
                    width = $urandom_range(0, FRAME_DIM);
                    height = $urandom_range(0, FRAME_DIM);
                end
                min_pts = (phase == BIG_MIN_PHASE) ? $urandom_range(0, 4194304)
                                                   : $urandom_range(0, 25);
            end
            write_reg(CFG_LOWER_BGR, lo_bgr);
            write_reg(CFG_UPPER_BGR, hi_bgr);
            write_reg(CFG_CROP_LEFT, CFG_DATA_W'(left));
            write_reg(CFG_CROP_TOP, CFG_DATA_W'(top));
            write_reg(CFG_CROP_WIDTH, CFG_DATA_W'(width));
            write_reg(CFG_CROP_HEIGHT, CFG_DATA_W'(height));
            write_reg(CFG_MIN_POINTS, CFG_DATA_W'(min_pts));

            no_idle = (phase == 1 || phase == PRESSURE_PHASE);
            hold_request = (phase == PRESSURE_PHASE);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // short frames in the pressure phase, under back-pressure, so finished frames pile up
                len = (phase == PRESSURE_PHASE) ? $urandom_range(1, 3) : $urandom_range(1, 40);
                if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
                for (int k = 0; k < len; k++) begin
                    p.x = COORD_W'(pick_coord(int'(model_cfg.crop_left),
                                              int'(model_cfg.crop_width)));
                    p.y = COORD_W'(pick_coord(int'(model_cfg.crop_top),
                                              int'(model_cfg.crop_height)));
                    p.blue = CHAN_W'(pick_level(int'(model_cfg.lower_bgr[7:0]),
                                                int'(model_cfg.upper_bgr[7:0])));
                    p.green = CHAN_W'(pick_level(int'(model_cfg.lower_bgr[15:8]),
                                                 int'(model_cfg.upper_bgr[15:8])));
                    p.red = CHAN_W'(pick_level(int'(model_cfg.lower_bgr[23:16]),
                                               int'(model_cfg.upper_bgr[23:16])));
                    p.frame_end = (k == len - 1);
                    send_pixel(p, 1'b0, '0);
                    sent++;
                end
            end
        end

        no_idle = 1'b0;
        wait_idle();
        if (mismatches == 0 && pending_centroids.size() == 0 && frame_notes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_pix_if.sv
hw/rtl/cbc_res_if.sv
hw/rtl/cbc_cfg_if.sv
hw/rtl/cbc_front.sv
hw/rtl/cbc_queue.sv
hw/rtl/cbc_back.sv
hw/rtl/color_blob_centroid_core.sv
bench/tb_top.sv
